[src/key_matrix_debouncer_macros.svh]
// assertion macros used by the key matrix debouncer checker
// no dependencies; included by bare file name
`ifndef KEY_MATRIX_DEBOUNCER_MACROS_SVH
`define KEY_MATRIX_DEBOUNCER_MACROS_SVH

// clocked property with a reset qualifier
`define KMD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// same, on the usual clock and reset names of the block
`define KMD_ASSERT(lbl, prop, msg) \
    `KMD_ASSERT_RST(lbl, i_clk, i_rst_n, prop, msg)

`endif

[src/kmd_pkg.sv]
// types and constants of the key matrix debouncer
// no dependencies
`default_nettype none

package kmd_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_EOS    = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    localparam logic       KIND_COMMIT    = 1'b0;
    localparam logic       KIND_READ      = 1'b1;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd5;
    localparam logic [7:0] QUIET_MAX      = 8'hFF;
    localparam int         MAX_ROWS       = 8;
    localparam int         MAX_COLS       = 8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic sample;
        logic tick;
        logic commit;
        logic read;
        logic emit;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic commit_ok;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[src/key_matrix_debouncer.sv]
// a read beat's reply is registered and shows in the cycle after acceptance
// a commit enters the emit state, then registers row 0, then one row per cycle while
// the receiver is ready; one beat per cycle enters while idle, reads and end-of-scan
// beats need a free output; bursts block input and share the stable-store read port
// reset (synchronous, active low) clears both row stores, the quiet counter and
// settling flag, and loads debounce_ticks with 5
`default_nettype none

module key_matrix_debouncer #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [2:0] i_row_index,
    input  logic [7:0] i_column_pins,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_reply_kind,
    output logic [2:0] o_out_row,
    output logic [7:0] o_row_keys,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_debounce_ticks
);

    kmd_pkg::t_cmd    cmd;
    kmd_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    kmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    kmd_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_row_index          (i_row_index),
        .i_column_pins        (i_column_pins),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_debounce_ticks (i_cfg_debounce_ticks),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_reply_kind         (o_reply_kind),
        .o_out_row            (o_out_row),
        .o_row_keys           (o_row_keys),
        .o_last               (o_last)
    );

endmodule

`default_nettype wire

[src/kmd_ctrl.sv]
// controller of the key matrix debouncer: accepts beats, sequences commit bursts
// depends on kmd_pkg
`default_nettype none

module kmd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_opcode,
    input  kmd_pkg::t_status i_status,
    output logic             o_in_ready,
    output kmd_pkg::t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_state           n_state;
    kmd_pkg::t_opcode op;
    logic             accept;

    always_comb begin
        op = kmd_pkg::t_opcode'(i_opcode);
        // samples and ticks never touch the output register
        o_in_ready = (r_state == S_IDLE) &&
                     (i_status.out_free || op == kmd_pkg::OP_SAMPLE ||
                      op == kmd_pkg::OP_TICK);
        accept = i_in_valid && o_in_ready;

        o_cmd.sample = accept && (op == kmd_pkg::OP_SAMPLE);
        o_cmd.tick   = accept && (op == kmd_pkg::OP_TICK);
        o_cmd.commit = accept && (op == kmd_pkg::OP_EOS) && i_status.commit_ok;
        o_cmd.read   = accept && (op == kmd_pkg::OP_READ);
        o_cmd.emit   = (r_state == S_EMIT) && i_status.out_free;

        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.commit) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (o_cmd.emit && i_status.emit_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[src/kmd_datapath.sv]
// datapath of the key matrix debouncer: row stores, quiet counter, output register
// depends on kmd_pkg
`default_nettype none

module kmd_datapath #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kmd_pkg::t_cmd    i_cmd,
    output kmd_pkg::t_status o_status,
    input  logic [2:0]       i_row_index,
    input  logic [7:0]       i_column_pins,
    input  logic             i_cfg_valid,
    input  logic [7:0]       i_cfg_debounce_ticks,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_reply_kind,
    output logic [2:0]       o_out_row,
    output logic [7:0]       o_row_keys,
    output logic             o_last
);

    // only the first eight rows and columns are reachable through the fields
    localparam int NR = (ROWS > kmd_pkg::MAX_ROWS) ? kmd_pkg::MAX_ROWS : ROWS;
    localparam int NC = (COLS > kmd_pkg::MAX_COLS) ? kmd_pkg::MAX_COLS : COLS;
    localparam int IW = (NR > 1) ? $clog2(NR) : 1;
    localparam logic [3:0]    NR_W     = 4'(NR);
    localparam logic [IW-1:0] LAST_ROW = IW'(NR - 1);

    logic [NC-1:0] r_raw    [NR];
    logic [NC-1:0] r_stable [NR];
    logic          r_settling;
    logic [7:0]    r_quiet;
    logic [7:0]    n_quiet;
    logic [7:0]    r_ticks;
    logic [IW-1:0] r_cnt;
    logic          r_out_valid;
    logic          r_kind;
    logic [2:0]    r_row;
    logic [7:0]    r_keys;
    logic          r_last;

    logic          in_range;
    logic [IW-1:0] idx;
    logic [IW-1:0] rd_addr;
    logic [NC-1:0] rd_data;
    logic [NC-1:0] pins_inv;
    logic          raw_change;

    always_comb begin
        in_range   = {1'b0, i_row_index} < NR_W;
        idx        = i_row_index[IW-1:0];
        pins_inv   = ~i_column_pins[NC-1:0];
        raw_change = in_range && (r_raw[idx] != pins_inv);
        // one read port on the stable store, shared by bursts and reads
        rd_addr    = i_cmd.emit ? r_cnt : idx;
        rd_data    = r_stable[rd_addr];

        n_quiet = r_quiet;
        if (i_cmd.sample && raw_change) begin
            n_quiet = '0;
        end else if (i_cmd.tick && r_quiet != kmd_pkg::QUIET_MAX) begin
            n_quiet = r_quiet + 8'd1;
        end

        o_status.commit_ok = r_settling && (r_quiet >= r_ticks);
        o_status.emit_last = (r_cnt == LAST_ROW);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NR; i++) begin
                r_raw[i]    <= '0;
                r_stable[i] <= '0;
            end
            r_settling  <= 1'b0;
            r_quiet     <= '0;
            r_ticks     <= kmd_pkg::DEBOUNCE_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_quiet <= n_quiet;
            if (i_cfg_valid) r_ticks <= i_cfg_debounce_ticks;

            if (i_cmd.sample && raw_change) begin
                r_raw[idx] <= pins_inv;
                r_settling <= 1'b1;
            end

            if (i_cmd.commit) begin
                for (int i = 0; i < NR; i++) begin
                    r_stable[i] <= r_raw[i];
                end
                r_settling <= 1'b0;
                r_cnt      <= '0;
            end else if (i_cmd.emit && !o_status.emit_last) begin
                r_cnt <= r_cnt + IW'(1);
            end

            if (i_cmd.emit || i_cmd.read) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= kmd_pkg::KIND_COMMIT;
            r_row  <= 3'(r_cnt);
            r_keys <= 8'(rd_data);
            r_last <= o_status.emit_last;
        end else if (i_cmd.read) begin
            r_kind <= kmd_pkg::KIND_READ;
            r_row  <= i_row_index;
            r_keys <= in_range ? 8'(rd_data) : 8'd0;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_reply_kind = r_kind;
    assign o_out_row    = r_row;
    assign o_row_keys   = r_keys;
    assign o_last       = r_last;

endmodule

`default_nettype wire

[src/kmd_checker.sv]
// port-level checks for the key matrix debouncer, bound to the top level
// depends on kmd_pkg and key_matrix_debouncer_macros.svh
`default_nettype none
`include "key_matrix_debouncer_macros.svh"

module kmd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_reply_kind,
    input logic [2:0] o_out_row,
    input logic [7:0] o_row_keys,
    input logic       o_last
);

    `KMD_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_reply_kind) && $stable(o_out_row) && $stable(o_row_keys) && $stable(o_last), "output beat changed while stalled")

    `KMD_ASSERT(a_read_last, o_out_valid && o_reply_kind == kmd_pkg::KIND_READ |-> o_last, "read reply without last")

    `KMD_ASSERT(a_burst_blocks, o_out_valid && o_reply_kind == kmd_pkg::KIND_COMMIT && !o_last |-> !o_in_ready, "input taken during a commit burst")

    `KMD_ASSERT(a_burst_next, o_out_valid && i_out_ready && o_reply_kind == kmd_pkg::KIND_COMMIT && !o_last |=> o_out_valid && o_reply_kind == kmd_pkg::KIND_COMMIT, "commit burst broke off")

endmodule

bind key_matrix_debouncer kmd_checker u_kmd_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for key_matrix_debouncer: random valid/ready pacing on both sides
// depends on kmd_pkg (src/kmd_pkg.sv) and the key_matrix_debouncer rtl
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         N_ROWS         = 8;
    localparam int         N_COLS         = 8;
    localparam int         N_EMIT         = (N_ROWS > 8) ? 8 : N_ROWS;
    localparam logic [7:0] COL_MASK       = (N_COLS >= 8) ? 8'hFF : 8'((1 << N_COLS) - 1);
    localparam int         HOLD_CYCLES    = 300;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        kmd_pkg::t_opcode op;
        logic [2:0]       row;
        logic [7:0]       pins;
    } t_scan_item;

    typedef struct packed {
        logic       kind;
        logic [2:0] row;
        logic [7:0] keys;
        logic       last;
    } t_key_beat;

    logic       i_clk                = 1'b0;
    logic       i_rst_n              = 1'b0;
    logic       i_in_valid           = 1'b0;
    logic [1:0] i_opcode             = kmd_pkg::OP_TICK;
    logic [2:0] i_row_index          = 3'd0;
    logic [7:0] i_column_pins        = 8'd0;
    logic       i_out_ready          = 1'b0;
    logic       i_cfg_valid          = 1'b0;
    logic [7:0] i_cfg_debounce_ticks = 8'd0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_reply_kind;
    logic [2:0] o_out_row;
    logic [7:0] o_row_keys;
    logic       o_last;
    logic       o_cfg_ready;

    // predictor state
    logic [7:0] raw_keys    [N_ROWS];
    logic [7:0] stable_keys [N_ROWS];
    logic       settling     = 1'b0;
    logic [7:0] quiet_ms     = 8'd0;
    logic [7:0] debounce_cfg = kmd_pkg::DEBOUNCE_RESET;

    // rows as they will stand once everything planned so far is applied
    logic [7:0] planned_raw [N_ROWS];

    t_scan_item pending_items [$];
    t_key_beat  expected_beats [$];
    t_scan_item cur_item;

    logic in_loaded  = 1'b0;
    logic no_idle    = 1'b0;
    logic hold_done  = 1'b0;
    int   in_gap     = 0;
    int   out_stall  = 0;
    int   hold_left  = 0;
    int   idle_cycles = 0;
    int   err_count  = 0;
    int   items_planned  = 0;
    int   items_accepted = 0;
    int   beats_checked  = 0;
    int   commit_count   = 0;
    int   settings_used  = 1;

    key_matrix_debouncer #(
        .ROWS (N_ROWS),
        .COLS (N_COLS)
    ) DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_opcode             (i_opcode),
        .i_row_index          (i_row_index),
        .i_column_pins        (i_column_pins),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_reply_kind         (o_reply_kind),
        .o_out_row            (o_out_row),
        .o_row_keys           (o_row_keys),
        .o_last               (o_last),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_debounce_ticks (i_cfg_debounce_ticks)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < N_ROWS; i++) begin
            raw_keys[i]    = 8'd0;
            stable_keys[i] = 8'd0;
            planned_raw[i] = 8'd0;
        end
    end

    // advance the debouncer state by one accepted beat and queue its results
    function automatic void debounce_step(input t_scan_item it);
        logic [7:0] keys;
        case (it.op)
            kmd_pkg::OP_SAMPLE: begin
                if (it.row < N_ROWS) begin
                    keys = ~it.pins & COL_MASK;
                    if (raw_keys[it.row] != keys) begin
                        raw_keys[it.row] = keys;
                        settling         = 1'b1;
                        quiet_ms         = 8'd0;
                    end
                end
            end
            kmd_pkg::OP_TICK: begin
                if (quiet_ms != kmd_pkg::QUIET_MAX)
                    quiet_ms = quiet_ms + 8'd1;
            end
            kmd_pkg::OP_EOS: begin
                if (settling && quiet_ms >= debounce_cfg) begin
                    for (int i = 0; i < N_ROWS; i++)
                        stable_keys[i] = raw_keys[i];
                    settling = 1'b0;
                    commit_count++;
                    for (int i = 0; i < N_EMIT; i++)
                        expected_beats.push_back('{kmd_pkg::KIND_COMMIT, 3'(i),
                            stable_keys[i], (i == N_EMIT - 1)});
                end
            end
            default: begin
                expected_beats.push_back('{kmd_pkg::KIND_READ, it.row,
                    (it.row < N_ROWS) ? stable_keys[it.row] : 8'd0, 1'b1});
            end
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_loaded && i_in_valid && o_in_ready) begin
                debounce_step(cur_item);
                items_accepted++;
                in_loaded = 1'b0;
                in_gap    = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (!in_loaded) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() > 0) begin
                    cur_item       = pending_items.pop_front();
                    in_loaded      = 1'b1;
                    i_opcode      <= cur_item.op;
                    i_row_index   <= cur_item.row;
                    i_column_pins <= cur_item.pins;
                end
            end
            i_in_valid <= in_loaded;
        end
    end

    // result monitor and receiver pacing
    always @(posedge i_clk) begin
        t_key_beat exp_beat;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with none expected: kind %0b row %0d keys %02h",
                           o_reply_kind, o_out_row, o_row_keys);
                    err_count++;
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (o_reply_kind !== exp_beat.kind) begin
                        $error("reply_kind: expected %0b, got %0b", exp_beat.kind, o_reply_kind);
                        err_count++;
                    end
                    if (o_out_row !== exp_beat.row) begin
                        $error("out_row: expected %0d, got %0d", exp_beat.row, o_out_row);
                        err_count++;
                    end
                    if (o_row_keys !== exp_beat.keys) begin
                        $error("row_keys: expected %02h, got %02h", exp_beat.keys, o_row_keys);
                        err_count++;
                    end
                    if (o_last !== exp_beat.last) begin
                        $error("last: expected %0b, got %0b", exp_beat.last, o_last);
                        err_count++;
                    end
                end
                beats_checked++;
                out_stall = no_idle ? 0 : $urandom_range(0, 19);
            end else if (out_stall > 0) begin
                out_stall--;
            end
            // one long hold-off while the sender still has plenty queued
            if (!hold_done && beats_checked >= 20 && pending_items.size() > 10) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            i_out_ready <= (out_stall == 0) && (hold_left == 0);
        end
    end

    // cycles without any accepted beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic void plan_item(input kmd_pkg::t_opcode op, input logic [2:0] row,
                                      input logic [7:0] pins);
        if (op == kmd_pkg::OP_SAMPLE && row < N_ROWS)
            planned_raw[row] = ~pins & COL_MASK;
        pending_items.push_back('{op, row, pins});
        items_planned++;
    endfunction

    function automatic void plan_filler(input kmd_pkg::t_opcode op);
        plan_item(op, 3'($urandom_range(0, 7)), 8'($urandom));
    endfunction

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_items.size() != 0 || in_loaded || expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_debounce(input logic [7:0] value);
        wait_idle();
        i_cfg_valid          <= 1'b1;
        i_cfg_debounce_ticks <= value;
        do
            @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        debounce_cfg = value;
        settings_used++;
        i_cfg_valid <= 1'b0;
    endtask

    // mostly full scans (row changes, ticks, end of scan), some broken scans and noise
    task automatic random_scans(input int n);
        int         target;
        int         kind;
        logic [2:0] row;
        logic [7:0] keys;
        target = items_planned + n;
        while (items_planned < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                plan_filler(kmd_pkg::t_opcode'($urandom_range(0, 3)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    row = 3'($urandom_range(0, 7));
                    case ($urandom_range(0, 2))
                        0:       keys = planned_raw[row];
                        1:       keys = planned_raw[row] ^ (8'h01 << $urandom_range(0, 7));
                        default: keys = 8'($urandom);
                    endcase
                    plan_item(kmd_pkg::OP_SAMPLE, row, ~keys);
                end
                // broken scans stop ticking early
                if (kind == 2)
                    repeat ($urandom_range(0, debounce_cfg / 2)) plan_filler(kmd_pkg::OP_TICK);
                else
                    repeat ($urandom_range(0, debounce_cfg + 2)) plan_filler(kmd_pkg::OP_TICK);
                plan_filler(kmd_pkg::OP_EOS);
                if ($urandom_range(0, 2) == 0)
                    plan_filler(kmd_pkg::OP_READ);
            end
        end
    endtask

    task automatic run_phases();
        // reset setting of 5
        plan_item(kmd_pkg::OP_READ, 3'd0, 8'h00);
        plan_item(kmd_pkg::OP_READ, 3'd7, 8'hFF);
        plan_item(kmd_pkg::OP_EOS, 3'd0, 8'h00);
        plan_item(kmd_pkg::OP_SAMPLE, 3'd0, 8'h00);
        plan_item(kmd_pkg::OP_SAMPLE, 3'd7, 8'hFF);
        plan_item(kmd_pkg::OP_SAMPLE, 3'd3, 8'hA5);
        plan_item(kmd_pkg::OP_EOS, 3'd7, 8'hFF);
        repeat (4) plan_filler(kmd_pkg::OP_TICK);
        plan_item(kmd_pkg::OP_EOS, 3'd0, 8'h00);
        plan_filler(kmd_pkg::OP_TICK);
        plan_item(kmd_pkg::OP_EOS, 3'd5, 8'h5A);
        plan_item(kmd_pkg::OP_READ, 3'd3, 8'h00);
        plan_item(kmd_pkg::OP_SAMPLE, 3'd0, 8'h00);
        plan_item(kmd_pkg::OP_EOS, 3'd0, 8'h00);
        plan_item(kmd_pkg::OP_SAMPLE, 3'd5, 8'hFE);
        repeat (6) plan_filler(kmd_pkg::OP_TICK);
        plan_item(kmd_pkg::OP_EOS, 3'd1, 8'h00);

        // zero setting commits on the first end of scan after a change
        write_debounce(8'd0);
        plan_item(kmd_pkg::OP_SAMPLE, 3'd1, 8'h7F);
        plan_filler(kmd_pkg::OP_EOS);
        plan_filler(kmd_pkg::OP_EOS);
        plan_item(kmd_pkg::OP_READ, 3'd1, 8'h00);
        plan_item(kmd_pkg::OP_SAMPLE, 3'd1, 8'hFF);
        plan_filler(kmd_pkg::OP_EOS);
        random_scans(40);

        // widest window, with the quiet counter running into saturation
        write_debounce(8'd255);
        no_idle = 1'b1;
        plan_item(kmd_pkg::OP_SAMPLE, 3'd2, ~(planned_raw[2] ^ 8'h80));
        repeat (254) plan_filler(kmd_pkg::OP_TICK);
        plan_filler(kmd_pkg::OP_EOS);
        repeat (46) plan_filler(kmd_pkg::OP_TICK);
        plan_filler(kmd_pkg::OP_EOS);
        plan_item(kmd_pkg::OP_READ, 3'd2, 8'h00);
        wait_idle();
        no_idle = 1'b0;

        write_debounce(8'd1);
        random_scans(30);

        write_debounce(8'($urandom_range(2, 9)));
        no_idle = 1'b1;
        random_scans(30);
        wait_idle();
        no_idle = 1'b0;

        write_debounce(8'd3);
        random_scans(30);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            run_phases();
            wait (idle_cycles >= WATCHDOG_LIMIT);
        join_any
        if (idle_cycles >= WATCHDOG_LIMIT)
            $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("%0d input beats under %0d debounce settings, %0d commits",
                 items_accepted, settings_used, commit_count);
        $display("%0d result beats checked, %0d mismatches", beats_checked, err_count);
        if (idle_cycles < WATCHDOG_LIMIT && err_count == 0 && expected_beats.size() == 0)
            $display("key_matrix_debouncer test passed");
        else
            $display("key_matrix_debouncer test failed");
        $finish;
    end

endmodule

`default_nettype wire
